[src/gvfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfc_pkg
// Types and constants shared by the gas ventilation fan controller files.
// ----------------------------------------------------------------------------
package gvfc_pkg;

  localparam int LEVEL_W    = 10;
  localparam int PERIOD_W   = 16;
  localparam int SECONDS_W  = 8;
  localparam int GAP_W      = 8;
  localparam int MANUAL_MS_W = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_GAS_THRESHOLD    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD_MS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_RUN_MS      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_RUN_S     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS      = 3'd4;

  localparam logic [LEVEL_W-1:0]   GAS_THRESHOLD_RESET    = 10'd800;
  localparam logic [PERIOD_W-1:0]  SAMPLE_PERIOD_MS_RESET = 16'd400;
  localparam logic [PERIOD_W-1:0]  AUTO_RUN_MS_RESET      = 16'd500;
  localparam logic [SECONDS_W-1:0] MANUAL_RUN_S_RESET     = 8'd8;
  localparam logic [GAP_W-1:0]     DEBOUNCE_MS_RESET      = 8'd50;

  typedef struct packed {
    logic [LEVEL_W-1:0] co2_level;
    logic [LEVEL_W-1:0] ch4_level;
    logic               display_button_edge;
    logic               fan_button_edge;
  } item_t;

  typedef struct packed {
    logic                 relay_on;
    logic                 display_on;
    logic [MODE_W-1:0]    fan_mode;
    logic [SECONDS_W-1:0] seconds_left;
    logic                 sampled;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

[src/gvfc_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gvfc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/gvfc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfc_core
// Configuration registers, controller state and the per-tick update that
// produces one result for each accepted tick.
// ----------------------------------------------------------------------------
module gvfc_core
  import gvfc_pkg::*;
#(
  parameter int MS_PER_SECOND = 1000
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg,
  input  logic       take,
  input  item_t      item,
  output result_t    res
);

  localparam logic [MANUAL_MS_W-1:0] MS_LIMIT = MANUAL_MS_W'(MS_PER_SECOND);

  logic [LEVEL_W-1:0]   gas_threshold;
  logic [PERIOD_W-1:0]  sample_period_ms;
  logic [PERIOD_W-1:0]  auto_run_ms;
  logic [SECONDS_W-1:0] manual_run_s;
  logic [GAP_W-1:0]     debounce_ms;

  logic [PERIOD_W-1:0]    sample_elapsed, sample_elapsed_next;
  logic [PERIOD_W-1:0]    hold_left, hold_left_next;
  logic [SECONDS_W-1:0]   manual_seconds, manual_seconds_next;
  logic [MANUAL_MS_W-1:0] manual_ms, manual_ms_next;
  logic [MODE_W-1:0]      mode, mode_next;
  logic                   relay, relay_next;
  logic                   display_state, display_state_next;
  logic                   fan_request, fan_request_next;
  logic [GAP_W-1:0]       display_gap, display_gap_next;
  logic [GAP_W-1:0]       fan_gap, fan_gap_next;

  logic [GAP_W-1:0]       display_gap_inc, fan_gap_inc;
  logic [PERIOD_W-1:0]    elapsed_inc, hold_dec;
  logic [MANUAL_MS_W-1:0] ms_inc;
  logic [SECONDS_W-1:0]   seconds_dec;
  logic                   sampled;

  always_ff @(posedge clk) begin
    if (rst) begin
      gas_threshold    <= GAS_THRESHOLD_RESET;
      sample_period_ms <= SAMPLE_PERIOD_MS_RESET;
      auto_run_ms      <= AUTO_RUN_MS_RESET;
      manual_run_s     <= MANUAL_RUN_S_RESET;
      debounce_ms      <= DEBOUNCE_MS_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_GAS_THRESHOLD:    gas_threshold    <= cfg.data[LEVEL_W-1:0];
        REG_SAMPLE_PERIOD_MS: sample_period_ms <= cfg.data[PERIOD_W-1:0];
        REG_AUTO_RUN_MS:      auto_run_ms      <= cfg.data[PERIOD_W-1:0];
        REG_MANUAL_RUN_S:     manual_run_s     <= cfg.data[SECONDS_W-1:0];
        REG_DEBOUNCE_MS:      debounce_ms      <= cfg.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    display_gap_inc = (display_gap != '1) ? display_gap + 1'b1 : display_gap;
    fan_gap_inc     = (fan_gap != '1) ? fan_gap + 1'b1 : fan_gap;
    elapsed_inc     = (sample_elapsed != '1) ? sample_elapsed + 1'b1 : sample_elapsed;
    hold_dec        = (hold_left != '0) ? hold_left - 1'b1 : hold_left;
    ms_inc          = manual_ms + 1'b1;
    seconds_dec     = (manual_seconds != '0) ? manual_seconds - 1'b1 : manual_seconds;

    display_gap_next   = item.display_button_edge ? '0 : display_gap_inc;
    fan_gap_next       = item.fan_button_edge ? '0 : fan_gap_inc;
    display_state_next = display_state ^
                         (item.display_button_edge && (display_gap_inc > debounce_ms));
    fan_request_next   = fan_request ^
                         (item.fan_button_edge && (fan_gap_inc > debounce_ms));

    sample_elapsed_next = elapsed_inc;
    hold_left_next      = hold_left;
    manual_seconds_next = manual_seconds;
    manual_ms_next      = manual_ms;
    mode_next           = mode;
    relay_next          = relay;
    sampled             = 1'b0;

    if (mode == MODE_MANUAL) begin
      if (!fan_request_next) begin
        mode_next = MODE_SAMPLE;
      end else if (ms_inc >= MS_LIMIT) begin
        manual_ms_next      = '0;
        manual_seconds_next = seconds_dec;
        if (seconds_dec == '0) begin
          mode_next        = MODE_SAMPLE;
          fan_request_next = 1'b0;
        end
      end else begin
        manual_ms_next = ms_inc;
      end
    end else if (fan_request_next) begin
      mode_next           = MODE_MANUAL;
      relay_next          = 1'b1;
      manual_seconds_next = manual_run_s;
      manual_ms_next      = '0;
    end else if (mode == MODE_HOLD) begin
      hold_left_next = hold_dec;
      if (hold_dec == '0) begin
        mode_next = MODE_SAMPLE;
      end
    end else if (elapsed_inc >= sample_period_ms) begin
      sample_elapsed_next = '0;
      sampled             = 1'b1;
      if ((item.co2_level > gas_threshold) || (item.ch4_level > gas_threshold)) begin
        relay_next = 1'b1;
        if (auto_run_ms != '0) begin
          mode_next      = MODE_HOLD;
          hold_left_next = auto_run_ms;
        end
      end else begin
        relay_next = 1'b0;
      end
    end

    res.relay_on     = relay_next;
    res.display_on   = display_state_next;
    res.fan_mode     = mode_next;
    res.seconds_left = (mode_next == MODE_MANUAL) ? manual_seconds_next : '0;
    res.sampled      = sampled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_elapsed <= '0;
      hold_left      <= '0;
      manual_seconds <= '0;
      manual_ms      <= '0;
      mode           <= MODE_SAMPLE;
      relay          <= 1'b0;
      display_state  <= 1'b1;
      fan_request    <= 1'b0;
      display_gap    <= '0;
      fan_gap        <= '0;
    end else if (take) begin
      sample_elapsed <= sample_elapsed_next;
      hold_left      <= hold_left_next;
      manual_seconds <= manual_seconds_next;
      manual_ms      <= manual_ms_next;
      mode           <= mode_next;
      relay          <= relay_next;
      display_state  <= display_state_next;
      fan_request    <= fan_request_next;
      display_gap    <= display_gap_next;
      fan_gap        <= fan_gap_next;
    end
  end

endmodule

[src/gas_ventilation_fan_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ventilation_fan_controller
// Debounced buttons, periodic gas evaluation, automatic hold and timed
// manual fan run, one millisecond tick per transaction.
// ----------------------------------------------------------------------------
// The block takes one tick transaction per clock cycle while its input is ready
// and returns one registered result transaction per tick. The whole
// state update for a tick is combinational logic, which sets the rate of
// one tick per cycle. A two-entry output buffer lets the block accept a new
// tick while an earlier result is still waiting; the input stalls only when
// both entries are full. Configuration writes are taken at any time and
// should be issued only while no tick is outstanding.
module gas_ventilation_fan_controller
  import gvfc_pkg::*;
#(
  parameter int MS_PER_SECOND = 1000
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  gvfc_stream_if.sink            items,
  gvfc_stream_if.source          results
);

  cfg_write_t cfg;
  result_t    res;
  logic       take;
  logic       out_free;
  logic       out_valid;
  result_t    out_data;
  logic       skid_valid;
  result_t    skid_data;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign items.ready   = !skid_valid;
  assign take          = items.valid && !skid_valid;
  assign out_free      = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  gvfc_core #(
    .MS_PER_SECOND(MS_PER_SECOND)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .take(take),
    .item(items.data),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_data <= skid_data;
      end
    end else if (take) begin
      if (out_free) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

endmodule

[src/gvfc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfc_checker
// Port-level checks on the result channel of the fan controller.
// ----------------------------------------------------------------------------
module gvfc_checker
  import gvfc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_seconds_manual_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.fan_mode != MODE_MANUAL) |-> out_data.seconds_left == '0)
    else $error("Seconds left shown outside manual run.");

  a_hold_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.fan_mode == MODE_HOLD) |-> out_data.relay_on)
    else $error("Relay off during automatic hold.");

  a_sample_not_manual: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sampled |-> out_data.fan_mode != MODE_MANUAL)
    else $error("Evaluation reported during manual run.");

endmodule

bind gas_ventilation_fan_controller gvfc_checker u_gvfc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_data (results.data)
);

[dv/gas_ventilation_fan_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ventilation_fan_controller_test
// Self-checking bench for the fan controller. A cycle-level predictor follows
// every accepted tick transaction and its status is checked against the block.
// Directed ticks come first, then random tick streams under several register
// settings. Those settings include the extremes and a manual run that times
// out. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
module gas_ventilation_fan_controller_test;
  import gvfc_pkg::*;

  localparam int TICKS_PER_SECOND = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gvfc_stream_if #(.payload_t(item_t))   tick_if ();
  gvfc_stream_if #(.payload_t(result_t)) status_if ();

  gas_ventilation_fan_controller #(.MS_PER_SECOND(TICKS_PER_SECOND)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (tick_if),
    .results   (status_if)
  );

  // Register copies held by the predictor.
  logic [LEVEL_W-1:0]   cfg_threshold = GAS_THRESHOLD_RESET;
  logic [PERIOD_W-1:0]  cfg_period    = SAMPLE_PERIOD_MS_RESET;
  logic [PERIOD_W-1:0]  cfg_hold      = AUTO_RUN_MS_RESET;
  logic [SECONDS_W-1:0] cfg_run_s     = MANUAL_RUN_S_RESET;
  logic [GAP_W-1:0]     cfg_debounce  = DEBOUNCE_MS_RESET;

  // Controller state held by the predictor.
  logic [PERIOD_W-1:0]    since_sample = '0;
  logic [PERIOD_W-1:0]    hold_count   = '0;
  logic [SECONDS_W-1:0]   run_seconds  = '0;
  logic [MANUAL_MS_W-1:0] run_ms       = '0;
  logic [MODE_W-1:0]      fan_state    = MODE_SAMPLE;
  logic                   relay_state  = 1'b0;
  logic                   display_state = 1'b1;
  logic                   fan_wanted   = 1'b0;
  logic [GAP_W-1:0]       display_quiet = '0;
  logic [GAP_W-1:0]       fan_quiet     = '0;

  item_t   tick_queue[$];
  result_t expected_status[$];

  int  mismatches = 0;
  int  status_count = 0;
  bit  no_idle = 1'b0;
  int  tx_calm = 0;
  int  rx_calm = 0;
  int  tx_idle = 0;
  int  rx_wait = 0;
  int  tx_gap;
  int  rx_gap;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic next_gap(inout int calm, output int gap);
    if (no_idle) begin
      gap = 0;
    end else if (calm > 0) begin
      calm = calm - 1;
      gap = 0;
    end else begin
      if ($urandom_range(0, 63) == 0) calm = int'($urandom_range(20, 60));
      gap = int'($urandom_range(0, 16));
    end
  endtask

  // Returns {press counts, new quiet count}.
  function automatic logic [GAP_W:0] button_step(logic [GAP_W-1:0] quiet, logic press);
    logic [GAP_W-1:0] q;
    q = quiet;
    if (q != 8'hFF) q = q + 8'd1;
    if (press) return {q > cfg_debounce, 8'h00};
    return {1'b0, q};
  endfunction

  function automatic result_t predict_tick(item_t tick);
    logic [GAP_W:0] btn;
    result_t status;
    status = '0;
    btn = button_step(display_quiet, tick.display_button_edge);
    display_quiet = btn[GAP_W-1:0];
    if (btn[GAP_W]) display_state = ~display_state;
    btn = button_step(fan_quiet, tick.fan_button_edge);
    fan_quiet = btn[GAP_W-1:0];
    if (btn[GAP_W]) fan_wanted = ~fan_wanted;

    if (since_sample != 16'hFFFF) since_sample = since_sample + 16'd1;

    if (fan_state == MODE_MANUAL) begin
      if (!fan_wanted) begin
        fan_state = MODE_SAMPLE;
      end else begin
        run_ms = run_ms + 10'd1;
        if (int'(run_ms) >= TICKS_PER_SECOND) begin
          run_ms = '0;
          if (run_seconds != 0) run_seconds = run_seconds - 8'd1;
          if (run_seconds == 0) begin
            fan_state = MODE_SAMPLE;
            fan_wanted = 1'b0;
          end
        end
      end
    end else if (fan_wanted) begin
      fan_state = MODE_MANUAL;
      relay_state = 1'b1;
      run_seconds = cfg_run_s;
      run_ms = '0;
    end else if (fan_state == MODE_HOLD) begin
      if (hold_count != 0) hold_count = hold_count - 16'd1;
      if (hold_count == 0) fan_state = MODE_SAMPLE;
    end else if (since_sample >= cfg_period) begin
      since_sample = '0;
      status.sampled = 1'b1;
      if (tick.co2_level > cfg_threshold || tick.ch4_level > cfg_threshold) begin
        relay_state = 1'b1;
        if (cfg_hold != 0) begin
          fan_state = MODE_HOLD;
          hold_count = cfg_hold;
        end
      end else begin
        relay_state = 1'b0;
      end
    end

    status.relay_on = relay_state;
    status.display_on = display_state;
    status.fan_mode = fan_state;
    status.seconds_left = (fan_state == MODE_MANUAL) ? run_seconds : 8'd0;
    return status;
  endfunction

  // Tick driver.
  always @(posedge clk) begin
    if (rst) begin
      tick_if.valid <= 1'b0;
      tick_if.data <= '0;
      tx_idle <= 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        expected_status.push_back(predict_tick(tick_if.data));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tx_idle > 0) begin
          tx_idle <= tx_idle - 1;
          tick_if.valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          tick_if.data <= tick_queue.pop_front();
          tick_if.valid <= 1'b1;
          next_gap(tx_calm, tx_gap);
          tx_idle <= tx_gap;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor.
  always @(posedge clk) begin
    if (rst) begin
      status_if.ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (status_if.valid && status_if.ready) begin
        status_count <= status_count + 1;
        if (expected_status.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("status %0d arrived with none expected", status_count);
        end else begin
          result_t want;
          want = expected_status.pop_front();
          if (status_if.data.relay_on !== want.relay_on ||
              status_if.data.display_on !== want.display_on ||
              status_if.data.fan_mode !== want.fan_mode ||
              status_if.data.seconds_left !== want.seconds_left ||
              status_if.data.sampled !== want.sampled) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("status %0d: expected relay %0b display %0b mode %0d secs %0d sampled %0b",
                       status_count, want.relay_on, want.display_on, want.fan_mode,
                       want.seconds_left, want.sampled);
              $display("status %0d:      got relay %0b display %0b mode %0d secs %0d sampled %0b",
                       status_count, status_if.data.relay_on, status_if.data.display_on,
                       status_if.data.fan_mode, status_if.data.seconds_left,
                       status_if.data.sampled);
            end
          end
        end
        next_gap(rx_calm, rx_gap);
        if (rx_gap == 0) begin
          status_if.ready <= 1'b1;
        end else begin
          status_if.ready <= 1'b0;
          rx_wait <= rx_gap;
        end
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        if (rx_wait == 1) status_if.ready <= 1'b1;
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_GAS_THRESHOLD:    cfg_threshold = value[LEVEL_W-1:0];
      REG_SAMPLE_PERIOD_MS: cfg_period = value[PERIOD_W-1:0];
      REG_AUTO_RUN_MS:      cfg_hold = value[PERIOD_W-1:0];
      REG_MANUAL_RUN_S:     cfg_run_s = value[SECONDS_W-1:0];
      REG_DEBOUNCE_MS:      cfg_debounce = value[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int thr, int period, int hold, int run_s, int deb);
    write_reg(REG_GAS_THRESHOLD, thr);
    write_reg(REG_SAMPLE_PERIOD_MS, period);
    write_reg(REG_AUTO_RUN_MS, hold);
    write_reg(REG_MANUAL_RUN_S, run_s);
    write_reg(REG_DEBOUNCE_MS, deb);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (tick_queue.size() != 0 || tick_if.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_tick(int co2, int ch4, bit disp, bit fan);
    item_t t;
    t.co2_level = co2[LEVEL_W-1:0];
    t.ch4_level = ch4[LEVEL_W-1:0];
    t.display_button_edge = disp;
    t.fan_button_edge = fan;
    tick_queue.push_back(t);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int sel;
    int v;
    sel = int'($urandom_range(0, 3));
    case (sel)
      0: return LEVEL_W'($urandom_range(0, 1023));
      1: begin
        v = int'(cfg_threshold) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[LEVEL_W-1:0];
      end
      2: return ($urandom_range(0, 1) == 1) ? 10'h3FF : 10'h000;
      default: return LEVEL_W'($urandom_range(0, int'(cfg_threshold)));
    endcase
  endfunction

  task automatic run_phase(int thr, int period, int hold, int run_s, int deb, int count,
                           int disp_rate, int fan_rate, int forced_fan, bit fast);
    bit d;
    bit f;
    no_idle = fast;
    configure(thr, period, hold, run_s, deb);
    for (int i = 0; i < count; i++) begin
      d = (disp_rate > 0) && ($urandom_range(0, disp_rate - 1) == 0);
      f = ((fan_rate > 0) && ($urandom_range(0, fan_rate - 1) == 0)) || (i == forced_fan);
      push_tick(pick_level(), pick_level(), d, f);
    end
    settle();
    no_idle = 1'b0;
  endtask

  initial begin
    tick_if.valid = 1'b0;
    tick_if.data = '0;
    status_if.ready = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: early button edges are ignored.
    push_tick(1023, 1023, 1, 1);
    push_tick(0, 0, 1, 1);
    push_tick(1023, 0, 0, 0);
    push_tick(0, 1023, 0, 0);
    settle();

    // Zero threshold, zero period, no hold, no debounce.
    configure(0, 0, 0, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(1, 0, 0, 0);
    push_tick(0, 1, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 1, 0);
    push_tick(0, 0, 0, 1);
    push_tick(0, 0, 0, 1);
    settle();

    // Threshold edge, short hold, fan request during hold, early stop.
    configure(1022, 1, 3, 0, 0);
    push_tick(1022, 1022, 0, 0);
    push_tick(1023, 0, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 1, 0);
    push_tick(0, 0, 0, 1);
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 0, 1);
    push_tick(0, 1023, 0, 0);
    settle();

    run_phase(800, 400, 500, 8, 50, 150, 30, 30, -1, 1'b0);
    run_phase(0, 1, 0, 255, 0, 100, 4, 8, -1, 1'b0);
    run_phase(1023, 65535, 65535, 255, 255, 100, 3, 3, -1, 1'b0);
    // A single fan press lets a manual run time out.
    run_phase($urandom_range(300, 700), 3, 7, 0, 10, 1100, 20, 0, 50, 1'b0);
    run_phase($urandom_range(0, 1023), $urandom_range(1, 40), $urandom_range(0, 60),
              1, $urandom_range(0, 20), 100, 25, 200, -1, 1'b0);
    run_phase($urandom_range(0, 1023), $urandom_range(1, 50), $urandom_range(0, 80),
              $urandom_range(0, 3), $urandom_range(0, 40), 100, 15, 15, -1, 1'b0);
    run_phase(512, 2, 1, 2, 1, 100, 10, 50, -1, 1'b1);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
